### design/mmbd_pkg.sv
// Package for the memory map bus decoder: transfer payload types, decode
// result struct, region and register select codes and memory map constants.
// No dependencies.
`default_nettype none

package mmbd_pkg;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Target codes reported with every result.
    localparam logic [3:0] TGT_INTERNAL = 4'd0;
    localparam logic [3:0] TGT_CART     = 4'd1;
    localparam logic [3:0] TGT_BOOT     = 4'd2;
    localparam logic [3:0] TGT_JOYPAD   = 4'd3;
    localparam logic [3:0] TGT_TIMER    = 4'd4;
    localparam logic [3:0] TGT_IFLAGS   = 4'd5;
    localparam logic [3:0] TGT_PALETTE  = 4'd6;
    localparam logic [3:0] TGT_TILE     = 4'd7;
    localparam logic [3:0] TGT_UNMAPPED = 4'd8;

    // Internal memory selects.
    localparam logic [2:0] MEM_NONE = 3'd0;
    localparam logic [2:0] MEM_VRAM = 3'd1;
    localparam logic [2:0] MEM_ERAM = 3'd2;
    localparam logic [2:0] MEM_WRAM = 3'd3;
    localparam logic [2:0] MEM_OAM  = 3'd4;
    localparam logic [2:0] MEM_HRAM = 3'd5;

    // Internal register selects.
    localparam logic [2:0] REG_NONE = 3'd0;
    localparam logic [2:0] REG_LCDC = 3'd1;
    localparam logic [2:0] REG_STAT = 3'd2;
    localparam logic [2:0] REG_SCY  = 3'd3;
    localparam logic [2:0] REG_SCX  = 3'd4;
    localparam logic [2:0] REG_LY   = 3'd5;
    localparam logic [2:0] REG_LYC  = 3'd6;
    localparam logic [2:0] REG_IE   = 3'd7;

    // Memory sizes.
    localparam int RAM_DEPTH  = 8192;
    localparam int RAM_AW     = 13;
    localparam int OAM_DEPTH  = 160;
    localparam int OAM_AW     = 8;
    localparam int HRAM_DEPTH = 128;
    localparam int HRAM_AW    = 7;

    // Memory map boundaries.
    localparam logic [15:0] ADDR_VRAM      = 16'h8000;
    localparam logic [15:0] ADDR_MAP_BASE  = 16'h9800;
    localparam logic [15:0] ADDR_ERAM      = 16'hA000;
    localparam logic [15:0] ADDR_WRAM      = 16'hC000;
    localparam logic [15:0] ADDR_OAM       = 16'hFE00;
    localparam logic [15:0] ADDR_PROHIB    = 16'hFEA0;
    localparam logic [15:0] ADDR_IO        = 16'hFF00;
    localparam logic [15:0] ADDR_HRAM      = 16'hFF80;
    localparam logic [15:0] ADDR_IE        = 16'hFFFF;
    localparam logic [15:0] ADDR_BOOT_END  = 16'h0100;
    localparam logic [15:0] ADDR_BOOT_SPAN = 16'h1000;
    localparam logic [15:0] PC_BOOT_EXIT   = 16'h0100;
    localparam logic [7:0]  STAT_WR_MASK   = 8'hFC;
    localparam logic [7:0]  RD_UNMAPPED_IO = 8'hFF;

    // Low address bytes of the I/O page.
    localparam logic [7:0] IO_JOYPAD   = 8'h00;
    localparam logic [7:0] IO_TIMER_LO = 8'h04;
    localparam logic [7:0] IO_TIMER_HI = 8'h07;
    localparam logic [7:0] IO_IFLAGS   = 8'h0F;
    localparam logic [7:0] IO_LCDC     = 8'h40;
    localparam logic [7:0] IO_STAT     = 8'h41;
    localparam logic [7:0] IO_SCY      = 8'h42;
    localparam logic [7:0] IO_SCX      = 8'h43;
    localparam logic [7:0] IO_LY       = 8'h44;
    localparam logic [7:0] IO_LYC      = 8'h45;
    localparam logic [7:0] IO_PAL_LO   = 8'h47;
    localparam logic [7:0] IO_PAL_HI   = 8'h49;

    // One bus access.
    typedef struct packed {
        logic        op;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [15:0] cpu_pc;
        logic [7:0]  scan_line;
        logic [1:0]  lcd_mode;
    } t_in_item;

    // One decoded result.
    typedef struct packed {
        logic [7:0]  read_data;
        logic [3:0]  target;
        logic [15:0] target_offset;
    } t_out_item;

    // Decode of one access, passed from the decoder to the register file and top.
    typedef struct packed {
        logic [3:0]  target;
        logic [15:0] offset;
        logic [2:0]  mem_sel;
        logic [12:0] mem_idx;
        logic [2:0]  reg_sel;
        logic        rd_ff;
        logic        boot_retire;
    } t_dec;

endpackage

`default_nettype wire

### design/mmbd_ram.sv
// Single-port byte-wide RAM with registered read data.
// Standalone; depth set by parameter.
`default_nettype none

module mmbd_ram #(
    parameter int DEPTH = 256
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire                       i_re,
    input  wire [$clog2(DEPTH)-1:0]   i_addr,
    input  wire [7:0]                 i_wdata,
    output logic [7:0]                o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port and registered read port share one address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/mmbd_decode.sv
// Address decoder: maps one bus access onto a target, offset and internal
// memory or register select. Depends on mmbd_pkg.
`default_nettype none

module mmbd_decode (
    input  wire mmbd_pkg::t_in_item i_item,
    input  wire                     i_boot_active,
    output mmbd_pkg::t_dec          o_dec
);

    logic        wr;
    logic [15:0] a;
    logic [7:0]  lo;

    assign wr = (i_item.op == mmbd_pkg::OP_WRITE);
    assign a  = i_item.address;
    assign lo = a[7:0];

    // Region decode in address order; the I/O page is decoded by its low byte.
    always_comb begin
        o_dec             = '0;
        o_dec.target      = mmbd_pkg::TGT_INTERNAL;
        o_dec.mem_sel     = mmbd_pkg::MEM_NONE;
        o_dec.reg_sel     = mmbd_pkg::REG_NONE;
        o_dec.mem_idx     = a[12:0];
        if (a < mmbd_pkg::ADDR_VRAM) begin
            o_dec.target = mmbd_pkg::TGT_CART;
            o_dec.offset = a;
            if (!wr && i_boot_active && a < mmbd_pkg::ADDR_BOOT_SPAN) begin
                if (a < mmbd_pkg::ADDR_BOOT_END) begin
                    o_dec.target = mmbd_pkg::TGT_BOOT;
                end else if (i_item.cpu_pc == mmbd_pkg::PC_BOOT_EXIT) begin
                    o_dec.boot_retire = 1'b1;
                end
            end
        end else if (a < mmbd_pkg::ADDR_ERAM) begin
            o_dec.mem_sel = mmbd_pkg::MEM_VRAM;
            // Writes to the tile data area also refresh the tile cache.
            if (wr && a < mmbd_pkg::ADDR_MAP_BASE) begin
                o_dec.target = mmbd_pkg::TGT_TILE;
                o_dec.offset = {3'b000, a[12:0]};
            end
        end else if (a < mmbd_pkg::ADDR_WRAM) begin
            o_dec.mem_sel = mmbd_pkg::MEM_ERAM;
        end else if (a < mmbd_pkg::ADDR_OAM) begin
            // Echo area folds onto work RAM through the low 13 bits.
            o_dec.mem_sel = mmbd_pkg::MEM_WRAM;
        end else if (a < mmbd_pkg::ADDR_PROHIB) begin
            o_dec.mem_sel = mmbd_pkg::MEM_OAM;
            o_dec.mem_idx = {5'b00000, a[7:0]};
        end else if (a < mmbd_pkg::ADDR_IO) begin
            o_dec.target = mmbd_pkg::TGT_UNMAPPED;
            o_dec.offset = a;
        end else if (a == mmbd_pkg::ADDR_IE) begin
            o_dec.reg_sel = mmbd_pkg::REG_IE;
        end else if (a >= mmbd_pkg::ADDR_HRAM) begin
            o_dec.mem_sel = mmbd_pkg::MEM_HRAM;
            o_dec.mem_idx = {6'b000000, a[6:0]};
        end else if (lo == mmbd_pkg::IO_JOYPAD) begin
            o_dec.target = mmbd_pkg::TGT_JOYPAD;
        end else if (lo >= mmbd_pkg::IO_TIMER_LO && lo <= mmbd_pkg::IO_TIMER_HI) begin
            o_dec.target = mmbd_pkg::TGT_TIMER;
            o_dec.offset = {14'd0, lo[1:0]};
        end else if (lo == mmbd_pkg::IO_IFLAGS) begin
            o_dec.target = mmbd_pkg::TGT_IFLAGS;
        end else if (lo >= mmbd_pkg::IO_PAL_LO && lo <= mmbd_pkg::IO_PAL_HI) begin
            o_dec.target = mmbd_pkg::TGT_PALETTE;
            o_dec.offset = {8'd0, 8'(lo - mmbd_pkg::IO_PAL_LO)};
        end else if (lo == mmbd_pkg::IO_LCDC) begin
            o_dec.reg_sel = mmbd_pkg::REG_LCDC;
        end else if (lo == mmbd_pkg::IO_STAT) begin
            o_dec.reg_sel = mmbd_pkg::REG_STAT;
        end else if (lo == mmbd_pkg::IO_SCY) begin
            o_dec.reg_sel = mmbd_pkg::REG_SCY;
        end else if (lo == mmbd_pkg::IO_SCX) begin
            o_dec.reg_sel = mmbd_pkg::REG_SCX;
        end else if (lo == mmbd_pkg::IO_LY) begin
            o_dec.reg_sel = mmbd_pkg::REG_LY;
        end else if (lo == mmbd_pkg::IO_LYC) begin
            o_dec.reg_sel = mmbd_pkg::REG_LYC;
        end else begin
            // Any other I/O address reads as all ones.
            o_dec.target = mmbd_pkg::TGT_UNMAPPED;
            o_dec.offset = a;
            o_dec.rd_ff  = 1'b1;
        end
    end

endmodule

`default_nettype wire

### design/mmbd_regs.sv
// LCD control, status, scroll and compare registers, interrupt enable and
// the boot overlay flag. Depends on mmbd_pkg.
`default_nettype none

module mmbd_regs (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_take,
    input  wire mmbd_pkg::t_in_item i_item,
    input  wire mmbd_pkg::t_dec     i_dec,
    input  wire                     i_cfg_we,
    input  wire                     i_cfg_data,
    output logic                    o_boot_active,
    output logic [7:0]              o_rdata
);

    logic [7:0] r_lcdc;
    logic [5:0] r_stat_sel;
    logic [7:0] r_scy;
    logic [7:0] r_scx;
    logic [7:0] r_lyc;
    logic [7:0] r_ie;
    logic       r_boot_active;
    logic       wr_take;
    logic [7:0] d;

    assign wr_take = i_take && (i_item.op == mmbd_pkg::OP_WRITE);
    assign d       = i_item.write_data;

    // Register writes; the line register is read only.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc     <= '0;
            r_stat_sel <= '0;
            r_scy      <= '0;
            r_scx      <= '0;
            r_lyc      <= '0;
            r_ie       <= '0;
        end else if (wr_take) begin
            unique case (i_dec.reg_sel)
                mmbd_pkg::REG_LCDC: r_lcdc     <= d;
                mmbd_pkg::REG_STAT: r_stat_sel <= 6'((d & mmbd_pkg::STAT_WR_MASK) >> 2);
                mmbd_pkg::REG_SCY:  r_scy      <= d;
                mmbd_pkg::REG_SCX:  r_scx      <= d;
                mmbd_pkg::REG_LYC:  r_lyc      <= d;
                mmbd_pkg::REG_IE:   r_ie       <= d;
                default: ;
            endcase
        end
    end

    // Boot overlay: armed or disarmed by configuration, retired by the exit read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_active <= 1'b0;
        end else if (i_cfg_we) begin
            r_boot_active <= i_cfg_data;
        end else if (i_take && i_dec.boot_retire) begin
            r_boot_active <= 1'b0;
        end
    end

    // Read value of the selected register; status low bits come from the LCD mode.
    always_comb begin
        unique case (i_dec.reg_sel)
            mmbd_pkg::REG_LCDC: o_rdata = r_lcdc;
            mmbd_pkg::REG_STAT: o_rdata = {r_stat_sel, i_item.lcd_mode};
            mmbd_pkg::REG_SCY:  o_rdata = r_scy;
            mmbd_pkg::REG_SCX:  o_rdata = r_scx;
            mmbd_pkg::REG_LY:   o_rdata = i_item.scan_line;
            mmbd_pkg::REG_LYC:  o_rdata = r_lyc;
            mmbd_pkg::REG_IE:   o_rdata = r_ie;
            default:            o_rdata = 8'd0;
        endcase
    end

    assign o_boot_active = r_boot_active;

endmodule

`default_nettype wire

### design/memory_map_bus_decoder.sv
// Memory map bus decoder: bus access decode with internal RAMs and registers.
// Depends on mmbd_pkg, mmbd_decode, mmbd_regs and mmbd_ram.
//
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_item) carries one CPU bus
//   access per transfer. Output channel (o_out_valid, i_out_stall,
//   o_out_item) returns one result per access, in order.
//   Configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_data) writes the
//   boot overlay enable; it is always ready.
//   A taken access is shown on the output in the cycle after it is taken.
//   One access per cycle is sustained while the receiver does not stall; the
//   rate is set by the single registered read port of each RAM together
//   with the result register.
//   Reset (synchronous, active low) clears the output valid flag, the clearing
//   pass state and the mmbd_regs registers, then a clearing pass writes zero
//   to every RAM entry, one address per cycle over all 8192 addresses. The
//   input is stalled during the pass; configuration writes are still taken.
//   When the receiver stalls, the result holds and the input stalls in the
//   same cycle.
`default_nettype none

module memory_map_bus_decoder (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire mmbd_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output mmbd_pkg::t_out_item      o_out_item,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire                      i_cfg_data
);

    localparam logic [mmbd_pkg::RAM_AW-1:0] CLR_LAST = '1;

    mmbd_pkg::t_dec dec;
    logic           take;
    logic           wr;
    logic           rd;
    logic           cfg_we;
    logic           boot_active;
    logic [7:0]     reg_rdata;

    logic                        r_clr_busy;
    logic [mmbd_pkg::RAM_AW-1:0] r_clr_addr;
    logic                        r_out_valid;
    logic                        r_out_wr;
    logic                        r_mem_rd;
    logic [2:0]                  r_mem_sel;
    logic [7:0]                  r_rd_fixed;
    logic [3:0]                  r_target;
    logic [15:0]                 r_offset;
    logic [7:0]                  n_rd_fixed;

    logic [mmbd_pkg::RAM_AW-1:0]  ram_addr;
    logic [mmbd_pkg::OAM_AW-1:0]  oam_addr;
    logic [mmbd_pkg::HRAM_AW-1:0] hram_addr;
    logic vram_we, eram_we, wram_we, oam_we, hram_we;
    logic vram_re, eram_re, wram_re, oam_re, hram_re;
    logic [7:0] vram_q, eram_q, wram_q, oam_q, hram_q;
    logic [7:0] wdata;
    logic [7:0] out_rdata;

    // Handshakes.
    assign o_in_stall  = r_clr_busy || (r_out_valid && i_out_stall);
    assign take        = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign wr          = (i_in_item.op == mmbd_pkg::OP_WRITE);
    assign rd          = !wr;

    mmbd_decode u_decode (
        .i_item        (i_in_item),
        .i_boot_active (boot_active),
        .o_dec         (dec)
    );

    mmbd_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_item        (i_in_item),
        .i_dec         (dec),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_boot_active (boot_active),
        .o_rdata       (reg_rdata)
    );

    // Clearing pass over all RAMs after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // RAM address, data and strobes; the clearing pass owns the ports while busy.
    assign ram_addr  = r_clr_busy ? r_clr_addr : dec.mem_idx;
    assign oam_addr  = r_clr_busy ? r_clr_addr[mmbd_pkg::OAM_AW-1:0]
                                  : dec.mem_idx[mmbd_pkg::OAM_AW-1:0];
    assign hram_addr = r_clr_busy ? r_clr_addr[mmbd_pkg::HRAM_AW-1:0]
                                  : dec.mem_idx[mmbd_pkg::HRAM_AW-1:0];
    assign wdata     = r_clr_busy ? 8'd0 : i_in_item.write_data;

    assign vram_we = r_clr_busy || (take && wr && dec.mem_sel == mmbd_pkg::MEM_VRAM);
    assign eram_we = r_clr_busy || (take && wr && dec.mem_sel == mmbd_pkg::MEM_ERAM);
    assign wram_we = r_clr_busy || (take && wr && dec.mem_sel == mmbd_pkg::MEM_WRAM);
    assign oam_we  = (r_clr_busy && r_clr_addr < mmbd_pkg::RAM_AW'(mmbd_pkg::OAM_DEPTH))
                   || (take && wr && dec.mem_sel == mmbd_pkg::MEM_OAM);
    assign hram_we = (r_clr_busy && r_clr_addr < mmbd_pkg::RAM_AW'(mmbd_pkg::HRAM_DEPTH))
                   || (take && wr && dec.mem_sel == mmbd_pkg::MEM_HRAM);

    assign vram_re = take && rd && dec.mem_sel == mmbd_pkg::MEM_VRAM;
    assign eram_re = take && rd && dec.mem_sel == mmbd_pkg::MEM_ERAM;
    assign wram_re = take && rd && dec.mem_sel == mmbd_pkg::MEM_WRAM;
    assign oam_re  = take && rd && dec.mem_sel == mmbd_pkg::MEM_OAM;
    assign hram_re = take && rd && dec.mem_sel == mmbd_pkg::MEM_HRAM;

    mmbd_ram #(.DEPTH(mmbd_pkg::RAM_DEPTH)) u_vram (
        .i_clk (i_clk), .i_we (vram_we), .i_re (vram_re),
        .i_addr (ram_addr), .i_wdata (wdata), .o_rdata (vram_q)
    );

    mmbd_ram #(.DEPTH(mmbd_pkg::RAM_DEPTH)) u_eram (
        .i_clk (i_clk), .i_we (eram_we), .i_re (eram_re),
        .i_addr (ram_addr), .i_wdata (wdata), .o_rdata (eram_q)
    );

    mmbd_ram #(.DEPTH(mmbd_pkg::RAM_DEPTH)) u_wram (
        .i_clk (i_clk), .i_we (wram_we), .i_re (wram_re),
        .i_addr (ram_addr), .i_wdata (wdata), .o_rdata (wram_q)
    );

    mmbd_ram #(.DEPTH(mmbd_pkg::OAM_DEPTH)) u_oam (
        .i_clk (i_clk), .i_we (oam_we), .i_re (oam_re),
        .i_addr (oam_addr), .i_wdata (wdata), .o_rdata (oam_q)
    );

    mmbd_ram #(.DEPTH(mmbd_pkg::HRAM_DEPTH)) u_hram (
        .i_clk (i_clk), .i_we (hram_we), .i_re (hram_re),
        .i_addr (hram_addr), .i_wdata (wdata), .o_rdata (hram_q)
    );

    // Non-memory read value: zero for writes, all ones for unmapped I/O, else the register read value.
    always_comb begin
        priority if (wr) begin
            n_rd_fixed = 8'd0;
        end else if (dec.rd_ff) begin
            n_rd_fixed = mmbd_pkg::RD_UNMAPPED_IO;
        end else begin
            n_rd_fixed = reg_rdata;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_wr   <= wr;
            r_mem_rd   <= rd && (dec.mem_sel != mmbd_pkg::MEM_NONE);
            r_mem_sel  <= dec.mem_sel;
            r_rd_fixed <= n_rd_fixed;
            r_target   <= dec.target;
            r_offset   <= dec.offset;
        end
    end

    // Read data comes from the RAM that was read, else from the result register.
    always_comb begin
        unique case (r_mem_sel)
            mmbd_pkg::MEM_VRAM: out_rdata = vram_q;
            mmbd_pkg::MEM_ERAM: out_rdata = eram_q;
            mmbd_pkg::MEM_WRAM: out_rdata = wram_q;
            mmbd_pkg::MEM_OAM:  out_rdata = oam_q;
            mmbd_pkg::MEM_HRAM: out_rdata = hram_q;
            default:            out_rdata = r_rd_fixed;
        endcase
    end

    assign o_out_valid              = r_out_valid;
    assign o_out_item.read_data     = r_mem_rd ? out_rdata : r_rd_fixed;
    assign o_out_item.target        = r_target;
    assign o_out_item.target_offset = r_offset;

    // No transfer is taken while the RAMs are being cleared.
    a_clr_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> o_in_stall)
        else $error("input taken during clearing pass");

    // No result can be pending during the clearing pass.
    a_clr_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_out_valid)
        else $error("result present during clearing pass");

    // The clearing pass ends only after the last address.
    a_clr_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> $past(r_clr_addr) == CLR_LAST)
        else $error("clearing pass ended early");

    // Writes always report zero read data.
    a_wr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_out_wr) |-> o_out_item.read_data == 8'd0)
        else $error("nonzero read data on a write");

    // Targets stay within the defined codes.
    a_tgt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.target <= mmbd_pkg::TGT_UNMAPPED)
        else $error("target code out of range");

endmodule

`default_nettype wire
